// ===== rtl/mpct_pkg.sv =====
// Package for the mouse packet cursor tracker: types, register indexes and
// reset values shared by the core, its submodules and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpct_pkg;

  // Mouse byte and configuration widths
  localparam int DATA_W    = 8;
  localparam int DIM_W     = 13;
  localparam int CSIZE_W   = 7;
  localparam int REG_IDX_W = 2;
  localparam int HALF_W    = DIM_W - 1;

  // Header bit positions
  localparam int SYNC_BIT   = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;

  // Register reset values
  localparam logic [DIM_W-1:0]   RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   RESET_HEIGHT = DIM_W'(480);
  localparam logic [CSIZE_W-1:0] RESET_CSIZE  = CSIZE_W'(24);

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_CURSOR_SIZE   = 2'd2
  } reg_index_t;

  // Position of a byte within its three-byte packet
  typedef enum logic [2:0] {
    BYTE_HDR = 3'b001,
    BYTE_X   = 3'b010,
    BYTE_Y   = 3'b100
  } byte_state_t;

  // Completed packet handed from the assembler to the update logic
  typedef struct packed {
    logic              fire;
    logic              sync;
    logic              x_neg;
    logic              y_neg;
    logic [DATA_W-1:0] x_move;
    logic [DATA_W-1:0] y_move;
  } pkt_t;

endpackage

`default_nettype wire

// ===== rtl/mpct_axis.sv =====
// One axis of the cursor update: add a signed 9-bit movement to the position
// and clamp to 0 .. screen size minus cursor size. Uses mpct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpct_axis #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0]        pos,
  input  wire logic [mpct_pkg::DATA_W-1:0]  move,
  input  wire logic                         neg,
  input  wire logic [mpct_pkg::DIM_W-1:0]   dim,
  input  wire logic [mpct_pkg::CSIZE_W-1:0] csize,
  output logic      [COORD_BITS-1:0]        pos_next
);
  import mpct_pkg::*;

  // Signed work width: holds position plus movement and the dimension bound
  localparam int SW = (COORD_BITS + 2 > DIM_W + 2) ? COORD_BITS + 2 : DIM_W + 2;
  localparam logic signed [SW-1:0] CoordMax = SW'((1 << COORD_BITS) - 1);

  logic signed [SW-1:0] step_s;
  logic signed [SW-1:0] sum_s;
  logic signed [SW-1:0] lim_s;
  logic signed [SW-1:0] bound_s;
  logic signed [SW-1:0] res_s;

  // Sign bit from the header forms a 9-bit two's complement movement
  assign step_s = {{(SW-DATA_W-1){neg}}, neg, move};
  assign sum_s  = {{(SW-COORD_BITS){1'b0}}, pos} + step_s;
  assign lim_s  = {{(SW-DIM_W){1'b0}}, dim} - {{(SW-CSIZE_W){1'b0}}, csize};

  // Saturate the upper bound to the coordinate range
  assign bound_s = (lim_s > CoordMax) ? CoordMax : lim_s;

  // Clamp; a negative bound pins the axis at zero
  always_comb begin
    if (lim_s[SW-1] || sum_s[SW-1]) begin
      res_s = '0;
    end else if (sum_s > bound_s) begin
      res_s = bound_s;
    end else begin
      res_s = sum_s;
    end
  end

  assign pos_next = res_s[COORD_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/mpct_assembler.sv =====
// Input register and packet assembly: takes one mouse byte per transfer,
// tracks its place in the packet and presents a completed packet. Uses mpct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpct_assembler (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [mpct_pkg::DATA_W-1:0] data_byte,
  input  wire logic                        res_free,
  output logic                             in_stall,
  output mpct_pkg::pkt_t                   pkt
);
  import mpct_pkg::*;

  logic              byte_vld;
  logic [DATA_W-1:0] byte_q;
  byte_state_t       byte_state;
  byte_state_t       byte_state_next;
  logic [DATA_W-1:0] header;
  logic [DATA_W-1:0] x_move;
  logic              is_third;
  logic              advance;
  logic              in_xfer;

  // Decode the packet position of the held byte
  always_comb begin
    unique case (byte_state)
      BYTE_HDR: begin
        is_third        = 1'b0;
        byte_state_next = BYTE_X;
      end
      BYTE_X: begin
        is_third        = 1'b0;
        byte_state_next = BYTE_Y;
      end
      default: begin
        is_third        = 1'b1;
        byte_state_next = BYTE_HDR;
      end
    endcase
  end

  // A third byte moves on only when the result register can take it
  assign advance  = byte_vld && (!is_third || res_free);
  assign in_stall = byte_vld && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Hold the input byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else begin
      byte_vld <= in_xfer || in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_q <= data_byte;
    end
  end

  // Advance the packet position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_state <= BYTE_HDR;
    end else if (advance) begin
      byte_state <= byte_state_next;
    end
  end

  // Capture header and X movement
  always_ff @(posedge clk) begin
    if (advance && byte_state == BYTE_HDR) begin
      header <= byte_q;
    end
    if (advance && byte_state == BYTE_X) begin
      x_move <= byte_q;
    end
  end

  assign pkt.fire   = advance && is_third;
  assign pkt.sync   = header[SYNC_BIT];
  assign pkt.x_neg  = header[X_SIGN_BIT];
  assign pkt.y_neg  = header[Y_SIGN_BIT];
  assign pkt.x_move = x_move;
  assign pkt.y_move = byte_q;

endmodule

`default_nettype wire

// ===== rtl/mouse_packet_cursor_tracker_core.sv =====
// Top level of the mouse packet cursor tracker: configuration registers,
// cursor position and result register. Uses mpct_pkg, mpct_assembler, mpct_axis.
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   in        | in_valid, in_stall, data_byte             | byte in
//   out       | out_valid, out_stall, cursor_x, cursor_y, | result out
//             | packet_valid                              |
//   config    | wr_en, wr_index, wr_data                  | write in
//
// One byte per cycle is taken unless stalled. A byte is held in the input
// register; a third byte goes on into the result register once that is free.
// The input stalls only while a third byte waits on a stalled, full result
// register. Synchronous reset restores 640x480, cursor size 24, cursor centered.
`timescale 1ns / 1ps
`default_nettype none

module mouse_packet_cursor_tracker_core #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [mpct_pkg::DATA_W-1:0]    data_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [COORD_BITS-1:0]          cursor_x,
  output logic      [COORD_BITS-1:0]          cursor_y,
  output logic                                packet_valid,
  input  wire logic                           wr_en,
  input  wire logic [mpct_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [mpct_pkg::DIM_W-1:0]     wr_data
);
  import mpct_pkg::*;

  localparam int CoordMax = (1 << COORD_BITS) - 1;
  localparam int HW       = (COORD_BITS > HALF_W) ? COORD_BITS : HALF_W;
  localparam int ResetX   = (640 / 2 > CoordMax) ? CoordMax : 640 / 2;
  localparam int ResetY   = (480 / 2 > CoordMax) ? CoordMax : 480 / 2;
  localparam logic [HW-1:0] CoordMaxW = HW'(CoordMax);

  logic [DIM_W-1:0]      screen_width;
  logic [DIM_W-1:0]      screen_height;
  logic [CSIZE_W-1:0]    cursor_edge;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic [COORD_BITS-1:0] new_x;
  logic [COORD_BITS-1:0] new_y;
  logic [HW-1:0]         half_w;
  logic [COORD_BITS-1:0] centre;
  logic                  res_free;
  pkt_t                  pkt;

  // Result register is free when empty or its transfer completes now
  assign res_free = !out_valid || !out_stall;

  mpct_assembler u_assembler (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .data_byte(data_byte),
    .res_free (res_free),
    .in_stall (in_stall),
    .pkt      (pkt)
  );

  mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .pos     (pos_x),
    .move    (pkt.x_move),
    .neg     (pkt.x_neg),
    .dim     (screen_width),
    .csize   (cursor_edge),
    .pos_next(new_x)
  );

  mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .pos     (pos_y),
    .move    (pkt.y_move),
    .neg     (pkt.y_neg),
    .dim     (screen_height),
    .csize   (cursor_edge),
    .pos_next(new_y)
  );

  // Center of a written dimension, saturated to the coordinate range
  assign half_w = HW'(wr_data[DIM_W-1:1]);
  assign centre = (half_w > CoordMaxW) ? CoordMaxW[COORD_BITS-1:0] : half_w[COORD_BITS-1:0];

  // Apply a synced packet; otherwise keep the position
  assign pos_x_next = (pkt.fire && pkt.sync) ? new_x : pos_x;
  assign pos_y_next = (pkt.fire && pkt.sync) ? new_y : pos_y;

  // Configuration registers and cursor position
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
      cursor_edge   <= RESET_CSIZE;
      pos_x         <= COORD_BITS'(ResetX);
      pos_y         <= COORD_BITS'(ResetY);
    end else begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      if (wr_en) begin
        unique case (wr_index)
          REG_SCREEN_WIDTH: begin
            screen_width <= wr_data;
            pos_x        <= centre;
          end
          REG_SCREEN_HEIGHT: begin
            screen_height <= wr_data;
            pos_y         <= centre;
          end
          REG_CURSOR_SIZE: begin
            cursor_edge <= wr_data[CSIZE_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result valid: set on a finished packet, drop after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pkt.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pkt.fire) begin
      cursor_x     <= pos_x_next;
      cursor_y     <= pos_y_next;
      packet_valid <= pkt.sync;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpct_checker.sv =====
// Port-level checker for mouse_packet_cursor_tracker_core, bound to it below.
// Uses mpct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpct_checker #(
  parameter int COORD_BITS = 12
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS-1:0] cursor_x,
  input wire logic [COORD_BITS-1:0] cursor_y,
  input wire logic                  packet_valid
);
  import mpct_pkg::*;

  localparam logic [1:0] OwedMax = 2'd2;

  byte_state_t phase;
  logic [1:0]  owed;
  logic        in_xfer;
  logic        out_xfer;
  logic        third_xfer;

  assign in_xfer    = in_valid && !in_stall;
  assign out_xfer   = out_valid && !out_stall;
  assign third_xfer = in_xfer && phase == BYTE_Y;

  // Track packet position of accepted bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= BYTE_HDR;
    end else if (in_xfer) begin
      unique case (phase)
        BYTE_HDR: phase <= BYTE_X;
        BYTE_X:   phase <= BYTE_Y;
        default:  phase <= BYTE_HDR;
      endcase
    end
  end

  // Count packets taken in whose result has not been transferred out
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + {1'b0, third_xfer} - {1'b0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
      && $stable(packet_valid))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> owed != 2'd0)
    else $error("result without a completed packet");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    owed <= OwedMax)
    else $error("more packets in flight than pipeline stages");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

endmodule

bind mouse_packet_cursor_tracker_core mpct_checker #(.COORD_BITS(COORD_BITS)) u_mpct_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .cursor_x    (cursor_x),
  .cursor_y    (cursor_y),
  .packet_valid(packet_valid)
);

`default_nettype wire

// ===== tb/sv/mouse_packet_cursor_tracker_core_tb.sv =====
// Self-checking bench for mouse_packet_cursor_tracker_core: streams mouse bytes, predicts
// each packet's cursor position and compares every transfer on the result port.
// Depends on mpct_pkg and the core; drives configuration writes between idle phases.
`timescale 1ns / 1ps

module mouse_packet_cursor_tracker_core_tb;
  import mpct_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int NUM_PHASES = 10;
  localparam int IDLE_SETTLE = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  applied;
  } cursor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DATA_W-1:0] data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic packet_valid;
  logic wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [DIM_W-1:0] wr_data = '0;

  // Pending mouse bytes and predicted cursor results
  logic [DATA_W-1:0] byte_q[$];
  cursor_result_t cursor_expect[$];

  // Predicted block state
  int scr_w = 640;
  int scr_h = 480;
  int cur_size = 24;
  int cur_x = 320;
  int cur_y = 240;
  byte_state_t pkt_pos = BYTE_HDR;
  logic [DATA_W-1:0] pkt_hdr = '0;
  logic [DATA_W-1:0] pkt_xmove = '0;

  int fail_count = 0;
  int results_seen = 0;
  int in_gap = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit in_sent = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bit held_long = 1'b0;

  mouse_packet_cursor_tracker_core #(.COORD_BITS(COORD_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_x(cursor_x),
    .cursor_y(cursor_y),
    .packet_valid(packet_valid),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    return (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Center of a screen dimension, saturated to the coordinate range
  function automatic int half_dim(input logic [DIM_W-1:0] dim);
    int c;
    c = int'(dim) / 2;
    return (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

  // Move one axis by a 9-bit signed step and clamp to the visible range
  function automatic int step_axis(input int pos, input logic [DATA_W-1:0] mv,
                                   input logic neg, input int dim);
    int delta;
    int lim;
    int p;
    delta = int'(mv) - (neg ? 256 : 0);
    lim = dim - cur_size;
    if (lim > COORD_MAX) lim = COORD_MAX;
    p = pos + delta;
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    if (p < 0) p = 0;
    return p;
  endfunction

  // Advance packet assembly by one byte; the third byte yields a cursor result
  task automatic track_byte(input logic [DATA_W-1:0] b);
    cursor_result_t res;
    case (pkt_pos)
      BYTE_HDR: begin
        pkt_hdr = b;
        pkt_pos = BYTE_X;
      end
      BYTE_X: begin
        pkt_xmove = b;
        pkt_pos = BYTE_Y;
      end
      default: begin
        pkt_pos = BYTE_HDR;
        res.applied = pkt_hdr[SYNC_BIT];
        if (pkt_hdr[SYNC_BIT]) begin
          cur_x = step_axis(cur_x, pkt_xmove, pkt_hdr[X_SIGN_BIT], scr_w);
          cur_y = step_axis(cur_y, b, pkt_hdr[Y_SIGN_BIT], scr_h);
        end
        res.x = cur_x[COORD_BITS-1:0];
        res.y = cur_y[COORD_BITS-1:0];
        cursor_expect.push_back(res);
      end
    endcase
  endtask

  // Write one register and mirror it in the predicted state
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH: begin
        scr_w = int'(val);
        cur_x = half_dim(val);
      end
      REG_SCREEN_HEIGHT: begin
        scr_h = int'(val);
        cur_y = half_dim(val);
      end
      REG_CURSOR_SIZE: cur_size = int'(val[CSIZE_W-1:0]);
      default: ;  // spare index: no register behind it
    endcase
  endtask

  // Hold until every byte is taken and every result has arrived, then let the pipe drain
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || cursor_expect.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Driver: offer the next pending byte, hold a stalled one, insert random gaps
  always @(negedge clk) begin
    if (!in_valid || in_sent) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_valid <= 1'b1;
        data_byte <= byte_q.pop_front();
        if ($urandom_range(0, 299) == 0) in_calm = !in_calm;
        in_gap = (in_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_sent = 1'b0;
  end

  // Receiver stall: random short stalls, one long hold-off to back up the input
  always @(negedge clk) begin
    if (hold_left == 0 && !held_long && results_seen >= 100) begin
      held_long = 1'b1;
      hold_left = $urandom_range(80, 160);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
      if (!out_calm && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        hold_left = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on each byte transfer, check each result transfer
  always @(posedge clk) begin
    cursor_result_t want;
    if (!rst && in_valid && !in_stall) begin
      track_byte(data_byte);
      in_sent = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (cursor_expect.size() == 0) begin
        $error("unexpected result: cursor_x %0d cursor_y %0d packet_valid %0d",
               cursor_x, cursor_y, packet_valid);
        fail_count++;
      end else begin
        want = cursor_expect.pop_front();
        if (cursor_x !== want.x) begin
          $error("cursor_x mismatch: expected %0d, actual %0d", want.x, cursor_x);
          fail_count++;
        end
        if (cursor_y !== want.y) begin
          $error("cursor_y mismatch: expected %0d, actual %0d", want.y, cursor_y);
          fail_count++;
        end
        if (packet_valid !== want.applied) begin
          $error("packet_valid mismatch: expected %0d, actual %0d", want.applied,
                 packet_valid);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer or write happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus: directed packets after reset, then random phases under varied settings
  initial begin
    int n;
    int r;
    logic [DATA_W-1:0] hdr;
    logic [DIM_W-1:0] csz;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes of movement, both sign bits, discarded packets, clamps on both ends
    byte_q = '{8'h08, 8'hFF, 8'hFF,   // largest positive step, clamp high on Y
               8'h38, 8'h00, 8'h00,   // largest negative step
               8'h38, 8'h00, 8'h00,   // clamp low on Y
               8'h00, 8'h55, 8'hAA,   // sync bit clear: discarded
               8'hF7, 8'h12, 8'h34,   // every bit but sync set: discarded
               8'hFF, 8'hFF, 8'hFF,   // minus one on both axes
               8'h08, 8'h00, 8'h00,   // zero move
               8'h18, 8'h01, 8'h80};  // X negative, Y positive
    wait_idle();

    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_SCREEN_WIDTH, 13'd4096);
          write_reg(REG_SCREEN_HEIGHT, 13'd4096);
          write_reg(REG_CURSOR_SIZE, 13'd1);
        end
        2: begin
          // cursor fills the whole screen: pinned at zero
          write_reg(REG_CURSOR_SIZE, 13'd64);
          write_reg(REG_SCREEN_WIDTH, 13'd64);
          write_reg(REG_SCREEN_HEIGHT, 13'd64);
        end
        3: begin
          // widest dimensions, zero cursor: clamp bound saturates
          write_reg(REG_SCREEN_WIDTH, 13'h1FFF);
          write_reg(REG_SCREEN_HEIGHT, 13'h1FFF);
          write_reg(REG_CURSOR_SIZE, 13'd0);
        end
        4: begin
          // cursor larger than the screen; size value masked to its width
          write_reg(REG_SCREEN_WIDTH, 13'd0);
          write_reg(REG_SCREEN_HEIGHT, 13'd10);
          write_reg(REG_CURSOR_SIZE, 13'h1FFF);
        end
        5: begin
          write_reg(REG_SPARE, 13'h1ABC);
          write_reg(REG_SCREEN_WIDTH, 13'd640);
          write_reg(REG_SCREEN_HEIGHT, 13'd480);
          write_reg(REG_CURSOR_SIZE, 13'd24);
        end
        default: begin
          r = $urandom_range(0, 99);
          if (r < 25) begin
            // size only: cursor must not move
            write_reg(REG_CURSOR_SIZE, 13'($urandom_range(0, 127)));
          end else begin
            write_reg(REG_SCREEN_WIDTH, ($urandom_range(0, 99) < 80) ?
                      13'($urandom_range(64, 4096)) : 13'($urandom_range(0, 8191)));
            write_reg(REG_SCREEN_HEIGHT, ($urandom_range(0, 99) < 80) ?
                      13'($urandom_range(64, 4096)) : 13'($urandom_range(0, 8191)));
            csz = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(1, 64)) :
                  13'($urandom_range(0, 8191));
            write_reg(REG_CURSOR_SIZE, csz);
          end
          if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 13'($urandom_range(0, 8191)));
        end
      endcase
      @(negedge clk);
      wr_en <= 1'b0;

      // Mostly synced packets with random content, some unsynced, a few stray bytes
      n = $urandom_range(200, 245);
      while (n > 0) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          byte_q.push_back(8'($urandom_range(0, 255)));
          n--;
        end else begin
          hdr = 8'($urandom_range(0, 255));
          if (r < 90) hdr[SYNC_BIT] = 1'b1;
          byte_q.push_back(hdr);
          byte_q.push_back(8'($urandom_range(0, 255)));
          byte_q.push_back(8'($urandom_range(0, 255)));
          n -= 3;
        end
      end
      wait_idle();
    end

    if (cursor_expect.size() != 0) begin
      $error("%0d expected results never arrived", cursor_expect.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mpct_pkg.sv
rtl/mpct_axis.sv
rtl/mpct_assembler.sv
rtl/mouse_packet_cursor_tracker_core.sv
rtl/mpct_checker.sv
tb/sv/mouse_packet_cursor_tracker_core_tb.sv
